// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; all sample on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies condition in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies condition in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_pkg
// Shared types and field widths of the date list sorter
// ----------------------------------------------------------------------------
package dls_pkg;

    // field widths of one date
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

    // stream data width, padded to whole bytes
    localparam int TDATA_W = ((KEY_W + 7) / 8) * 8;

    // sort key: year in the upper bits so a plain compare orders by date
    typedef logic [KEY_W-1:0] key_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/dls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_ram
// Simple dual-port date store: one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dls_ram #(
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  dls_pkg::key_t             wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output dls_pkg::key_t             rd_data
);

    dls_pkg::key_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/date_list_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_list_sorter
// Collects a list of dates and streams it back sorted by year, month, day
// ----------------------------------------------------------------------------
// Dates enter on the slave stream, tlast on the final date of a list. Each
// date is placed into a memory kept in ascending order by insertion: the
// entries above it move up one slot per cycle through the store's read and
// write ports, and the slave side is not ready while the insert runs. Dates
// that arrive while MAX_DATES are held are dropped and the overflow flag
// (tuser) is set on every result of that list. After the final date the
// list streams out, oldest first or newest first as the ascending register
// read at the final date says. A result is read from the store only once
// the previous read has reached the output register, and the slave side
// stays closed until the last result is taken. The store needs no clearing
// after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module date_list_sorter #(
    parameter int MAX_DATES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: bit 0 = ascending
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    // input dates
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dls_pkg::TDATA_W-1:0]  s_tdata,   // year[13:0], month[17:14], day[22:18]
    input  logic                         s_tlast,   // last_in
    // sorted dates
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dls_pkg::TDATA_W-1:0]  m_tdata,   // out_year[13:0], out_month[17:14],
                                                    // out_day[22:18]
    output logic                         m_tlast,   // last_out
    output logic                         m_tuser    // overflow
);

    localparam int AW = (MAX_DATES > 1) ? $clog2(MAX_DATES) : 1;
    localparam int CW = $clog2(MAX_DATES + 1);

    localparam int DAY_LO   = 0;
    localparam int MONTH_LO = dls_pkg::DAY_W;
    localparam int YEAR_LO  = dls_pkg::DAY_W + dls_pkg::MONTH_W;

    // control state
    dls_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            asc_reg;
    logic            last_reg, last_next;
    logic            dir_reg, dir_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    logic            issued_reg, issued_next;
    logic            rd_pend_reg, rd_pend_next;
    logic            out_valid_reg, out_valid_next;

    // payload
    dls_pkg::key_t   key_reg, key_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic            rd_last_reg, rd_last_next;
    logic            out_last_reg, out_last_next;
    dls_pkg::key_t   out_key_reg, out_key_next;

    // store ports
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    dls_pkg::key_t   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    dls_pkg::key_t   rd_data;

    // helpers
    logic            accept;
    logic            full;
    logic [CW-1:0]   cnt_m1;
    logic [AW-1:0]   last_idx;
    dls_pkg::key_t   in_key;
    logic            shift_up;
    logic            out_pop;
    logic            issue;

    dls_ram #(
        .DEPTH (MAX_DATES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake and key helpers
    assign s_tready = (state_reg == dls_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_key   = {s_tdata[22:18], s_tdata[17:14], s_tdata[13:0]} == '0 ? '0 :
                      {s_tdata[13:0], s_tdata[17:14], s_tdata[22:18]};
    assign full     = (count_reg == CW'(MAX_DATES));
    assign cnt_m1   = count_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign shift_up = (key_reg < rd_data);
    assign out_pop  = out_valid_reg && m_tready;
    assign issue    = (state_reg == dls_pkg::ST_OUT) && !issued_reg && !rd_pend_reg &&
                      (!out_valid_reg || m_tready);

    // next state and store access
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        dir_next       = dir_reg;
        rd_idx_next    = rd_idx_reg;
        issued_next    = issued_reg;
        rd_pend_next   = rd_pend_reg;
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        rd_last_next   = rd_last_reg;
        out_last_next  = out_last_reg;
        out_key_next   = out_key_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = key_reg;
        rd_en          = 1'b0;
        rd_addr        = pos_reg;

        case (state_reg)
            dls_pkg::ST_IDLE:
            begin
                rd_idx_next = '0;
                issued_next = 1'b0;
                if (accept)
                begin
                    last_next = s_tlast;
                    if (s_tlast)
                    begin
                        dir_next = asc_reg;
                    end
                    key_next = in_key;
                    if (full)
                    begin
                        ovf_next = 1'b1;
                        if (s_tlast)
                        begin
                            state_next = dls_pkg::ST_OUT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = in_key;
                        count_next = CW'(1);
                        if (s_tlast)
                        begin
                            state_next = dls_pkg::ST_OUT;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = last_idx;
                        pos_next   = count_reg[AW-1:0];
                        state_next = dls_pkg::ST_SHIFT;
                    end
                end
            end

            dls_pkg::ST_SHIFT:
            begin
                wr_en = 1'b1;
                if (shift_up)
                begin
                    // move the larger entry up one slot
                    wr_data  = rd_data;
                    pos_next = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = dls_pkg::ST_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    // slot found
                    count_next = count_reg + CW'(1);
                    state_next = last_reg ? dls_pkg::ST_OUT : dls_pkg::ST_IDLE;
                end
            end

            dls_pkg::ST_PLACE:
            begin
                // new date goes to the front
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = last_reg ? dls_pkg::ST_OUT : dls_pkg::ST_IDLE;
            end

            dls_pkg::ST_OUT:
            begin
                // drain the output register
                if (out_pop)
                begin
                    out_valid_next = 1'b0;
                end
                // load the item read last cycle
                if (rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = rd_data;
                    out_last_next  = rd_last_reg;
                end
                // issue the next read, forward or from the top
                rd_pend_next = issue;
                if (issue)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = dir_reg ? rd_idx_reg : (last_idx - rd_idx_reg);
                    rd_last_next = (rd_idx_reg == last_idx);
                    if (rd_idx_reg == last_idx)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                    end
                end
                // end of burst
                if (out_pop && out_last_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = dls_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dls_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dls_pkg::ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            asc_reg       <= 1'b1;
            last_reg      <= 1'b0;
            dir_reg       <= 1'b1;
            rd_idx_reg    <= '0;
            issued_reg    <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            dir_reg       <= dir_next;
            rd_idx_reg    <= rd_idx_next;
            issued_reg    <= issued_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                asc_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        rd_last_reg  <= rd_last_next;
        out_last_reg <= out_last_next;
        out_key_reg  <= out_key_next;
    end

    // result stream
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = ovf_reg;
    assign m_tdata  = {{(dls_pkg::TDATA_W - dls_pkg::KEY_W){1'b0}},
                       out_key_reg[DAY_LO +: dls_pkg::DAY_W],
                       out_key_reg[MONTH_LO +: dls_pkg::MONTH_W],
                       out_key_reg[YEAR_LO +: dls_pkg::YEAR_W]};

    // checks
    `ASSERT_IMPLIES(a_idle_no_result, s_tready, !m_tvalid, "result pending while taking dates")
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(MAX_DATES), "stored count above capacity")
    `ASSERT_IMPLIES(a_pend_slot_free, rd_pend_reg, !out_valid_reg, "read lands on a full register")
    `ASSERT_NEXT(a_burst_clears, m_tvalid && m_tready && m_tlast, count_reg == '0 && !ovf_reg,
                 "list state not cleared after burst")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking stream testbench for the date list sorter
// ----------------------------------------------------------------------------
// Lists of dates are fed on the slave stream from a queue of pending items.
// A scoreboard keeps its own copy of each list, sorts it when the final date
// is taken, and checks every sorted item on the master stream in order. Both
// sides idle in random bursts, the sort order is changed between lists, and
// one list runs past the store capacity so that dates are dropped.
// ----------------------------------------------------------------------------
module tb;

    localparam int YEAR_W       = dls_pkg::YEAR_W;
    localparam int MONTH_W      = dls_pkg::MONTH_W;
    localparam int DAY_W        = dls_pkg::DAY_W;
    localparam int KEY_W        = dls_pkg::KEY_W;
    localparam int TDATA_W      = dls_pkg::TDATA_W;
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYC    = 9;
    localparam int CAPACITY     = 64;
    localparam int SETTLE_CYC   = CAPACITY + 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_ITEMS = 140;
    localparam int PAD_W        = TDATA_W - KEY_W;

    // one date offered on the slave stream
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               last;
    } date_item_t;

    // one sorted date expected on the master stream
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               last;
        logic               ovf;
    } sorted_date_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata     = '0;
    logic               s_tlast     = 1'b0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    // pending stimulus and the scoreboard's copy of the block
    date_item_t     pending_dates[$];
    date_item_t     on_bus;
    date_item_t     recent_date = '0;
    dls_pkg::key_t  list_keys[$];
    logic           list_dropped   = 1'b0;
    logic           sort_ascending = 1'b1;
    sorted_date_t   expected_dates[$];
    sorted_date_t   got_date;
    sorted_date_t   want_date;

    int  dates_queued   = 0;
    int  dates_taken    = 0;
    int  random_queued  = 0;
    int  results_seen   = 0;
    int  lists_done     = 0;
    int  overflow_lists = 0;
    int  mismatches     = 0;
    int  quiet_cycles   = 0;
    int  src_gap        = 0;
    int  sink_gap       = 0;
    bit  calm           = 1'b0;

    date_list_sorter #(
        .MAX_DATES   (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // count a failure, report only the first few
    task automatic report_fault(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // store a taken date; on the final date sort the list into expectations
    task automatic take_date(input date_item_t it);
        dls_pkg::key_t ordered[$];
        dls_pkg::key_t k;
        int            j;
        if (list_keys.size() < CAPACITY)
            list_keys.push_back({it.year, it.month, it.day});
        else
            list_dropped = 1'b1;
        if (it.last)
        begin
            // insertion sort in the order selected when the list ends
            foreach (list_keys[i])
            begin
                k = list_keys[i];
                j = ordered.size();
                ordered.push_back(k);
                while (j > 0 && (sort_ascending ? (k < ordered[j-1]) : (k > ordered[j-1])))
                begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = k;
            end
            foreach (ordered[i])
                expected_dates.push_back({ordered[i], i == ordered.size() - 1, list_dropped});
            lists_done++;
            if (list_dropped)
                overflow_lists++;
            list_keys.delete();
            list_dropped = 1'b0;
        end
    endtask

    // random date: mostly plausible, some empty, raw bit patterns and repeats
    function automatic date_item_t random_date(input logic last_flag);
        date_item_t  it;
        logic [31:0] bits;
        int          pick;
        pick = $urandom_range(0, 99);
        bits = $urandom;
        if (pick < 60)
        begin
            it.year  = YEAR_W'($urandom_range(1900, 2100));
            it.month = MONTH_W'($urandom_range(1, 12));
            it.day   = DAY_W'($urandom_range(1, 31));
        end
        else if (pick < 72)
        begin
            it.year  = YEAR_W'($urandom_range(0, 9999));
            it.month = MONTH_W'($urandom_range(1, 12));
            it.day   = DAY_W'($urandom_range(1, 31));
        end
        else if (pick < 80)
            it = '0;
        else if (pick < 90)
        begin
            it.year  = bits[YEAR_W-1:0];
            it.month = bits[YEAR_W+MONTH_W-1:YEAR_W];
            it.day   = bits[KEY_W-1:YEAR_W+MONTH_W];
        end
        else
            it = recent_date;
        it.last     = last_flag;
        recent_date = it;
        return it;
    endfunction

    task automatic queue_date(input int y, input int m, input int d, input bit last_flag);
        date_item_t it;
        it.year  = YEAR_W'(y);
        it.month = MONTH_W'(m);
        it.day   = DAY_W'(d);
        it.last  = last_flag;
        pending_dates.push_back(it);
        dates_queued++;
    endtask

    task automatic queue_random_list(input int len);
        for (int i = 0; i < len; i++)
        begin
            pending_dates.push_back(random_date(i == len - 1));
            dates_queued++;
            random_queued++;
        end
    endtask

    // wait until every date is taken and every sorted date has come back
    task automatic drain();
        while (dates_taken != dates_queued || expected_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // change the sort order while the block is idle
    task automatic write_ascending(input logic value);
        drain();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sort_ascending = value;
    endtask

    // slave side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_gap  = 0;
        end
        else
        begin
            // item taken at this edge
            if (s_tvalid && s_tready)
            begin
                take_date(on_bus);
                dates_taken++;
            end
            // offer the next item once the bus is free
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_dates.size() == 0)
                    s_tvalid <= 1'b0;
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    src_gap = $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    on_bus = pending_dates.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{PAD_W{1'b0}}, on_bus.day, on_bus.month, on_bus.year};
                    s_tlast  <= on_bus.last;
                end
            end
        end
    end

    // master side monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_date = {m_tdata[YEAR_W-1:0], m_tdata[YEAR_W+MONTH_W-1:YEAR_W],
                            m_tdata[KEY_W-1:YEAR_W+MONTH_W], m_tlast, m_tuser};
                results_seen++;
                if (expected_dates.size() == 0)
                    report_fault($sformatf(
                        "unexpected sorted item: %0d-%0d-%0d last=%0b ovf=%0b",
                        got_date.year, got_date.month, got_date.day, got_date.last,
                        got_date.ovf));
                else
                begin
                    want_date = expected_dates.pop_front();
                    if (got_date !== want_date)
                        report_fault($sformatf(
                            {"sorted item %0d mismatch: expected %0d-%0d-%0d last=%0b ",
                             "ovf=%0b, got %0d-%0d-%0d last=%0b ovf=%0b"},
                            results_seen, want_date.year, want_date.month, want_date.day,
                            want_date.last, want_date.ovf, got_date.year, got_date.month,
                            got_date.day, got_date.last, got_date.ovf));
                end
            end
            // receiver stalls in bursts
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles where no item moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: %0d idle cycles, %0d dates pending, %0d sorted items pending",
                    quiet_cycles, dates_queued - dates_taken, expected_dates.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // oldest first: extremes, empty date, raw max bits, a tie
        write_ascending(1'b1);
        queue_date(2024, 2, 29, 0);
        queue_date(0, 0, 0, 0);
        queue_date(9999, 12, 31, 0);
        queue_date(16383, 15, 31, 0);
        queue_date(2024, 2, 29, 0);
        queue_date(2024, 3, 1, 0);
        queue_date(2023, 12, 31, 0);
        queue_date(1, 1, 1, 1);
        // list of one date
        queue_date(1970, 1, 1, 1);

        // newest first: keys differing in one field only, bad month, day 0
        write_ascending(1'b0);
        queue_date(0, 0, 0, 0);
        queue_date(2000, 6, 15, 0);
        queue_date(2000, 6, 16, 0);
        queue_date(2000, 7, 15, 0);
        queue_date(2001, 6, 15, 0);
        queue_date(0, 15, 0, 0);
        queue_date(5000, 0, 31, 1);
        // all dates equal
        queue_date(12, 5, 5, 0);
        queue_date(12, 5, 5, 0);
        queue_date(12, 5, 5, 1);

        // full store: the 65th date and the final date are dropped
        write_ascending(1'(($urandom_range(0, 1))));
        queue_random_list(CAPACITY + 2);
        queue_random_list($urandom_range(1, 12));

        // random phases of short lists
        while (random_queued < RANDOM_ITEMS - 20)
        begin
            write_ascending(1'(($urandom_range(0, 1))));
            repeat ($urandom_range(1, 3)) queue_random_list($urandom_range(1, 12));
        end

        // closing phase with no idling on either side
        drain();
        calm = 1'b1;
        write_ascending(~sort_ascending);
        queue_random_list($urandom_range(5, 10));
        queue_random_list($urandom_range(5, 10));
        drain();

        $display("run: %0d lists (%0d with dropped dates), %0d dates in, %0d sorted items checked",
            lists_done, overflow_lists, dates_taken, results_seen);
        $display("run: both sort orders, empty, out-of-range and repeated dates, full store");
        if (mismatches == 0 && expected_dates.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
